// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the fault aggregator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BFA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BFA_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);
`else
`define BFA_ASSERT(label, clk, rstn, prop, msg)
`define BFA_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

// ===== rtl/bfa_pkg.sv =====
// Types and constants of the battery fault aggregator.
package bfa_pkg;

    typedef struct packed {
        logic [4:0]         validity_bits;
        logic [4:0]         device_present;
        logic [7:0]         cell_states;
        logic [63:0]        cell_voltages_mv;
        logic [15:0]        cell_spread_mv;
        logic signed [23:0] flow_error_mw;
        logic signed [23:0] inverter_power_mw;
        logic [31:0]        now_ms;
        logic [1:0]         resistance_alarms;
        logic [23:0]        pack_resistance_uohm;
    } in_t;

    typedef struct packed {
        logic [13:0] fault_flags;
        logic [1:0]  severity;
    } out_t;

    typedef struct packed {
        logic [15:0] cell_overvoltage_mv;
        logic [15:0] cell_undervoltage_mv;
        logic [15:0] cell_imbalance_mv;
        logic [22:0] flow_tolerance_mw;
        logic [15:0] flow_tolerance_frac;
        logic [31:0] persist_ms;
    } cfg_t;

    typedef struct packed {
        logic tap;
        logic ov;
        logic uv;
    } cell_flags_t;

    typedef struct packed {
        logic [4:0]  validity_bits;
        logic [4:0]  device_present;
        cell_flags_t cells;
        logic        imbalance;
        logic        pack_r;
        logic        cell_r;
    } pre_flags_t;

    typedef struct packed {
        logic load;
        logic commit;
    } flow_ctl_t;

    localparam logic [2:0] REG_OV      = 3'd0;
    localparam logic [2:0] REG_UV      = 3'd1;
    localparam logic [2:0] REG_IMB     = 3'd2;
    localparam logic [2:0] REG_TOL_MW  = 3'd3;
    localparam logic [2:0] REG_TOL_FRC = 3'd4;
    localparam logic [2:0] REG_PERSIST = 3'd5;

    localparam logic [1:0] CELL_OK  = 2'd0;
    localparam logic [1:0] CELL_TAP = 2'd1;

    localparam logic [1:0] SEV_NORMAL  = 2'd0;
    localparam logic [1:0] SEV_WARNING = 2'd1;
    localparam logic [1:0] SEV_FAULT   = 2'd2;
    localparam logic [1:0] SEV_UNAVAIL = 2'd3;

    localparam int unsigned VB_PACKV   = 0;
    localparam int unsigned VB_BATTI   = 1;
    localparam int unsigned VB_INVI    = 2;
    localparam int unsigned VB_METRICS = 3;
    localparam int unsigned VB_FLOW    = 4;

    localparam int unsigned DP_ADC_A   = 0;
    localparam int unsigned DP_ADC_B   = 1;
    localparam int unsigned DP_CLIMATE = 2;
    localparam int unsigned DP_BMON    = 3;
    localparam int unsigned DP_IMON    = 4;

    localparam int unsigned FF_PACKV    = 0;
    localparam int unsigned FF_BATTI    = 1;
    localparam int unsigned FF_INVI     = 2;
    localparam int unsigned FF_ADC      = 3;
    localparam int unsigned FF_CELLMEAS = 4;
    localparam int unsigned FF_TAP      = 5;
    localparam int unsigned FF_OV       = 6;
    localparam int unsigned FF_UV       = 7;
    localparam int unsigned FF_IMB      = 8;
    localparam int unsigned FF_CLIMATE  = 9;
    localparam int unsigned FF_MONITOR  = 10;
    localparam int unsigned FF_PACKR    = 11;
    localparam int unsigned FF_CELLR    = 12;
    localparam int unsigned FF_FLOW     = 13;

    localparam logic [15:0] RST_OV      = 16'd3650;
    localparam logic [15:0] RST_UV      = 16'd2800;
    localparam logic [15:0] RST_IMB     = 16'd100;
    localparam logic [22:0] RST_TOL_MW  = 23'd5000;
    localparam logic [15:0] RST_TOL_FRC = 16'd6554;
    localparam logic [31:0] RST_PERSIST = 32'd10000;

endpackage

// ===== rtl/battery_fault_aggregator_core.sv =====
// An accepted transaction passes the first-stage registers, then the output register.
// Throughput: one transaction per cycle while the output is not stalled; the
// cell lanes run side by side, the tolerance multiply sits in the first stage, the
// flow timer updates in the second. Reset: configuration returns to defaults, flow
// timer and alarm clear, pipeline empties. No clearing pass.
`include "assert_macros.svh"
module battery_fault_aggregator_core #(
    parameter int unsigned CELL_COUNT = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bfa_pkg::in_t     s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output bfa_pkg::out_t    m_payload,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    bfa_pkg::cfg_t       cfg_reg;
    logic [2:0]          reg_idx;
    logic                cfg_wr;

    bfa_pkg::cell_flags_t lane_flags [CELL_COUNT];
    bfa_pkg::cell_flags_t cells_any;
    bfa_pkg::pre_flags_t  pre;
    bfa_pkg::pre_flags_t  pre_reg;
    logic                 s1_valid_reg;
    logic                 out_free;
    logic                 s1_move;
    logic                 accept;
    bfa_pkg::flow_ctl_t   flow_ctl;
    logic                 flow_alarm;
    bfa_pkg::out_t        merged;
    logic                 m_valid_reg;
    bfa_pkg::out_t        m_payload_reg;

    // APB configuration
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_overvoltage_mv  <= bfa_pkg::RST_OV;
            cfg_reg.cell_undervoltage_mv <= bfa_pkg::RST_UV;
            cfg_reg.cell_imbalance_mv    <= bfa_pkg::RST_IMB;
            cfg_reg.flow_tolerance_mw    <= bfa_pkg::RST_TOL_MW;
            cfg_reg.flow_tolerance_frac  <= bfa_pkg::RST_TOL_FRC;
            cfg_reg.persist_ms           <= bfa_pkg::RST_PERSIST;
        end else if (cfg_wr) begin
            case (reg_idx)
                bfa_pkg::REG_OV:      cfg_reg.cell_overvoltage_mv  <= pwdata[15:0];
                bfa_pkg::REG_UV:      cfg_reg.cell_undervoltage_mv <= pwdata[15:0];
                bfa_pkg::REG_IMB:     cfg_reg.cell_imbalance_mv    <= pwdata[15:0];
                bfa_pkg::REG_TOL_MW:  cfg_reg.flow_tolerance_mw    <= pwdata[22:0];
                bfa_pkg::REG_TOL_FRC: cfg_reg.flow_tolerance_frac  <= pwdata[15:0];
                bfa_pkg::REG_PERSIST: cfg_reg.persist_ms           <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bfa_pkg::REG_OV:      prdata = {16'd0, cfg_reg.cell_overvoltage_mv};
            bfa_pkg::REG_UV:      prdata = {16'd0, cfg_reg.cell_undervoltage_mv};
            bfa_pkg::REG_IMB:     prdata = {16'd0, cfg_reg.cell_imbalance_mv};
            bfa_pkg::REG_TOL_MW:  prdata = {9'd0, cfg_reg.flow_tolerance_mw};
            bfa_pkg::REG_TOL_FRC: prdata = {16'd0, cfg_reg.flow_tolerance_frac};
            bfa_pkg::REG_PERSIST: prdata = cfg_reg.persist_ms;
            default:              prdata = 32'd0;
        endcase
    end

    // pipeline control
    assign out_free = !m_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    assign flow_ctl.load   = accept;
    assign flow_ctl.commit = s1_move;

    // cell lanes
    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_lane
        bfa_cell_lane u_lane (
            .cell_state  (s_payload.cell_states[2*i +: 2]),
            .cell_mv     (s_payload.cell_voltages_mv[16*i +: 16]),
            .ov_limit_mv (cfg_reg.cell_overvoltage_mv),
            .uv_limit_mv (cfg_reg.cell_undervoltage_mv),
            .flags       (lane_flags[i])
        );
    end

    always_comb begin
        cells_any = '0;
        for (int i = 0; i < CELL_COUNT; i++) begin
            cells_any.tap = cells_any.tap | lane_flags[i].tap;
            cells_any.ov  = cells_any.ov  | lane_flags[i].ov;
            cells_any.uv  = cells_any.uv  | lane_flags[i].uv;
        end
    end

    always_comb begin
        pre.validity_bits  = s_payload.validity_bits;
        pre.device_present = s_payload.device_present;
        pre.cells          = cells_any;
        pre.imbalance      = s_payload.validity_bits[bfa_pkg::VB_METRICS]
                             && (s_payload.cell_spread_mv > cfg_reg.cell_imbalance_mv);
        pre.pack_r         = s_payload.resistance_alarms[0]
                             && (s_payload.pack_resistance_uohm != 24'd0);
        pre.cell_r         = s_payload.resistance_alarms[1];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pre_reg <= pre;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    bfa_flow_unit u_flow (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (flow_ctl),
        .flow_error_mw     (s_payload.flow_error_mw),
        .inverter_power_mw (s_payload.inverter_power_mw),
        .now_ms            (s_payload.now_ms),
        .flow_ok           (s_payload.validity_bits[bfa_pkg::VB_FLOW]),
        .cfg               (cfg_reg),
        .flow_alarm        (flow_alarm)
    );

    bfa_merge u_merge (
        .pre        (pre_reg),
        .flow_alarm (flow_alarm),
        .result     (merged)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_payload_reg <= merged;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `BFA_ASSERT(a_ready_when_out_empty, aclk, aresetn, (!m_valid_reg |-> s_ready), "input stalled with empty output stage")
    `BFA_ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn, (s_valid && s_ready), s1_valid_reg, "accepted transaction lost in first stage")
    `BFA_ASSERT(a_unavail_flags, aclk, aresetn, ((m_valid && m_payload.severity == bfa_pkg::SEV_UNAVAIL) |-> (m_payload.fault_flags[bfa_pkg::FF_PACKV] && m_payload.fault_flags[bfa_pkg::FF_BATTI] && m_payload.fault_flags[bfa_pkg::FF_INVI] && m_payload.fault_flags[bfa_pkg::FF_CELLMEAS])), "unavailable severity without its flags")

endmodule

// ===== rtl/bfa_cell_lane.sv =====
// One cell lane: tap fault and over/under-voltage checks for a single cell.
module bfa_cell_lane (
    input  logic [1:0]           cell_state,
    input  logic [15:0]          cell_mv,
    input  logic [15:0]          ov_limit_mv,
    input  logic [15:0]          uv_limit_mv,
    output bfa_pkg::cell_flags_t flags
);

    logic cell_ok;

    assign cell_ok   = (cell_state == bfa_pkg::CELL_OK);
    assign flags.tap = (cell_state == bfa_pkg::CELL_TAP);
    assign flags.ov  = cell_ok && (cell_mv > ov_limit_mv);
    assign flags.uv  = cell_ok && (cell_mv < uv_limit_mv);

endmodule

// ===== rtl/bfa_flow_unit.sv =====
// Power-flow mismatch check with persistence timer; multiply is registered.
module bfa_flow_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bfa_pkg::flow_ctl_t      ctl,
    input  logic signed [23:0]      flow_error_mw,
    input  logic signed [23:0]      inverter_power_mw,
    input  logic [31:0]             now_ms,
    input  logic                    flow_ok,
    input  bfa_pkg::cfg_t           cfg,
    output logic                    flow_alarm
);

    logic [23:0] err_raw;
    logic [23:0] pow_raw;
    logic [23:0] err_abs;
    logic [23:0] pow_abs;
    logic [39:0] prod;

    logic [23:0] err_abs_reg;
    logic [39:0] prod_reg;
    logic [31:0] now_reg;
    logic        flow_ok_reg;

    logic [31:0] since_reg;
    logic [31:0] since_next;
    logic        alarm_reg;
    logic        alarm_next;

    logic [23:0] rel;
    logic [23:0] tol;
    logic        mismatch;
    logic [31:0] elapsed;

    assign err_raw = flow_error_mw;
    assign pow_raw = inverter_power_mw;
    assign err_abs = err_raw[23] ? (~err_raw + 24'd1) : err_raw;
    assign pow_abs = pow_raw[23] ? (~pow_raw + 24'd1) : pow_raw;
    assign prod    = {16'd0, pow_abs} * {24'd0, cfg.flow_tolerance_frac};

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            err_abs_reg <= err_abs;
            prod_reg    <= prod;
            now_reg     <= now_ms;
            flow_ok_reg <= flow_ok;
        end
    end

    assign rel      = prod_reg[39:16];
    assign tol      = (rel > {1'b0, cfg.flow_tolerance_mw}) ? rel : {1'b0, cfg.flow_tolerance_mw};
    assign mismatch = err_abs_reg > tol;

    always_comb begin
        since_next = 32'd0;
        alarm_next = 1'b0;
        elapsed    = 32'd0;
        if (flow_ok_reg && mismatch) begin
            since_next = (since_reg == 32'd0) ? now_reg : since_reg;
            elapsed    = now_reg - since_next;
            alarm_next = alarm_reg || (elapsed > cfg.persist_ms);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_reg <= 32'd0;
            alarm_reg <= 1'b0;
        end else if (ctl.commit) begin
            since_reg <= since_next;
            alarm_reg <= alarm_next;
        end
    end

    assign flow_alarm = alarm_next;

endmodule

// ===== rtl/bfa_merge.sv =====
// Merge stage: assembles the fault flags and derives the severity.
module bfa_merge (
    input  bfa_pkg::pre_flags_t pre,
    input  logic                flow_alarm,
    output bfa_pkg::out_t       result
);

    logic [13:0] f;
    logic        any_fault;
    logic        any_warn;

    always_comb begin
        f = '0;
        f[bfa_pkg::FF_PACKV]    = !pre.validity_bits[bfa_pkg::VB_PACKV];
        f[bfa_pkg::FF_BATTI]    = !pre.validity_bits[bfa_pkg::VB_BATTI];
        f[bfa_pkg::FF_INVI]     = !pre.validity_bits[bfa_pkg::VB_INVI];
        f[bfa_pkg::FF_ADC]      = !pre.device_present[bfa_pkg::DP_ADC_A]
                                  && !pre.device_present[bfa_pkg::DP_ADC_B];
        f[bfa_pkg::FF_CELLMEAS] = f[bfa_pkg::FF_ADC]
                                  || !pre.validity_bits[bfa_pkg::VB_METRICS];
        f[bfa_pkg::FF_TAP]      = pre.cells.tap;
        f[bfa_pkg::FF_OV]       = pre.cells.ov;
        f[bfa_pkg::FF_UV]       = pre.cells.uv;
        f[bfa_pkg::FF_IMB]      = pre.imbalance;
        f[bfa_pkg::FF_CLIMATE]  = !pre.device_present[bfa_pkg::DP_CLIMATE];
        f[bfa_pkg::FF_MONITOR]  = !pre.device_present[bfa_pkg::DP_BMON]
                                  && !pre.device_present[bfa_pkg::DP_IMON];
        f[bfa_pkg::FF_PACKR]    = pre.pack_r;
        f[bfa_pkg::FF_CELLR]    = pre.cell_r;
        f[bfa_pkg::FF_FLOW]     = flow_alarm;

        any_fault = f[bfa_pkg::FF_PACKV] || f[bfa_pkg::FF_BATTI] || f[bfa_pkg::FF_INVI]
                    || f[bfa_pkg::FF_CELLMEAS] || f[bfa_pkg::FF_TAP] || f[bfa_pkg::FF_OV]
                    || f[bfa_pkg::FF_UV] || f[bfa_pkg::FF_PACKR] || f[bfa_pkg::FF_CELLR]
                    || f[bfa_pkg::FF_FLOW];
        any_warn  = f[bfa_pkg::FF_IMB] || f[bfa_pkg::FF_CLIMATE] || f[bfa_pkg::FF_MONITOR];

        result.fault_flags = f;
        if (f[bfa_pkg::FF_PACKV] && f[bfa_pkg::FF_BATTI] && f[bfa_pkg::FF_INVI]
            && f[bfa_pkg::FF_CELLMEAS]) begin
            result.severity = bfa_pkg::SEV_UNAVAIL;
        end else if (any_fault) begin
            result.severity = bfa_pkg::SEV_FAULT;
        end else if (any_warn) begin
            result.severity = bfa_pkg::SEV_WARNING;
        end else begin
            result.severity = bfa_pkg::SEV_NORMAL;
        end
    end

endmodule

// ===== test/fault_flag_checker.sv =====
// Fault aggregator checker: tracks the limit registers, predicts every result and compares.
`timescale 1ns / 1ps
module fault_flag_checker #(
    parameter int unsigned CELL_COUNT = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  bfa_pkg::in_t  s_payload,
    input  logic          m_valid,
    input  logic          m_ready,
    input  bfa_pkg::out_t m_payload,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic [31:0]   prdata,
    input  logic          pready,
    output int            mismatches,
    output int            pending,
    output int            graded,
    output int            flow_alarms
);
    import bfa_pkg::*;

    localparam cfg_t RESET_LIMITS = {RST_OV, RST_UV, RST_IMB, RST_TOL_MW, RST_TOL_FRC,
                                     RST_PERSIST};
    localparam logic [13:0] FAULT_MASK = 14'((1 << FF_PACKV) | (1 << FF_BATTI)
        | (1 << FF_INVI) | (1 << FF_CELLMEAS) | (1 << FF_TAP) | (1 << FF_OV) | (1 << FF_UV)
        | (1 << FF_PACKR) | (1 << FF_CELLR) | (1 << FF_FLOW));
    localparam logic [13:0] WARN_MASK = 14'((1 << FF_IMB) | (1 << FF_CLIMATE)
        | (1 << FF_MONITOR));

    cfg_t        limits;
    logic [31:0] mismatch_start_ms;
    logic        flow_alarm;
    out_t        expected_grades[$];

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: MISMATCH %s", $time, msg);
        end
    endtask

    function automatic out_t grade_tick(input in_t t);
        out_t        r;
        logic [13:0] f;
        logic [1:0]  st;
        logic [15:0] mv;
        logic [23:0] err_mag, pow_mag, rel_tol, tol;
        logic [39:0] prod;
        int          c;
        f = '0;
        f[FF_PACKV]    = !t.validity_bits[VB_PACKV];
        f[FF_BATTI]    = !t.validity_bits[VB_BATTI];
        f[FF_INVI]     = !t.validity_bits[VB_INVI];
        f[FF_ADC]      = !t.device_present[DP_ADC_A] && !t.device_present[DP_ADC_B];
        f[FF_CELLMEAS] = f[FF_ADC] || !t.validity_bits[VB_METRICS];
        for (c = 0; c < CELL_COUNT && c < 4; c++) begin
            st = t.cell_states[2*c +: 2];
            mv = t.cell_voltages_mv[16*c +: 16];
            if (st == CELL_TAP) begin
                f[FF_TAP] = 1'b1;
            end
            if (st == CELL_OK) begin
                if (mv > limits.cell_overvoltage_mv) f[FF_OV] = 1'b1;
                if (mv < limits.cell_undervoltage_mv) f[FF_UV] = 1'b1;
            end
        end
        f[FF_IMB]     = t.validity_bits[VB_METRICS]
                        && (t.cell_spread_mv > limits.cell_imbalance_mv);
        f[FF_CLIMATE] = !t.device_present[DP_CLIMATE];
        f[FF_MONITOR] = !t.device_present[DP_BMON] && !t.device_present[DP_IMON];
        f[FF_PACKR]   = t.resistance_alarms[0] && (t.pack_resistance_uohm != '0);
        f[FF_CELLR]   = t.resistance_alarms[1];

        // power-flow persistence timer; zero timestamp means not started
        err_mag = t.flow_error_mw[23] ? ~t.flow_error_mw + 24'd1 : t.flow_error_mw;
        pow_mag = t.inverter_power_mw[23] ? ~t.inverter_power_mw + 24'd1 : t.inverter_power_mw;
        prod    = pow_mag * limits.flow_tolerance_frac;
        rel_tol = prod[39:16];
        tol     = (rel_tol > {1'b0, limits.flow_tolerance_mw}) ? rel_tol
                                                              : {1'b0, limits.flow_tolerance_mw};
        if (t.validity_bits[VB_FLOW] && err_mag > tol) begin
            if (mismatch_start_ms == '0) begin
                mismatch_start_ms = t.now_ms;
            end
            if (t.now_ms - mismatch_start_ms > limits.persist_ms) begin
                flow_alarm = 1'b1;
            end
        end else begin
            mismatch_start_ms = '0;
            flow_alarm        = 1'b0;
        end
        f[FF_FLOW] = flow_alarm;

        r.fault_flags = f;
        if (f[FF_PACKV] && f[FF_BATTI] && f[FF_INVI] && f[FF_CELLMEAS]) begin
            r.severity = SEV_UNAVAIL;
        end else if (|(f & FAULT_MASK)) begin
            r.severity = SEV_FAULT;
        end else if (|(f & WARN_MASK)) begin
            r.severity = SEV_WARNING;
        end else begin
            r.severity = SEV_NORMAL;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        out_t        want;
        logic [31:0] held;
        if (!aresetn) begin
            limits            = RESET_LIMITS;
            mismatch_start_ms = '0;
            flow_alarm        = 1'b0;
            expected_grades.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[4:2])
                        REG_OV:      limits.cell_overvoltage_mv  = pwdata[15:0];
                        REG_UV:      limits.cell_undervoltage_mv = pwdata[15:0];
                        REG_IMB:     limits.cell_imbalance_mv    = pwdata[15:0];
                        REG_TOL_MW:  limits.flow_tolerance_mw    = pwdata[22:0];
                        REG_TOL_FRC: limits.flow_tolerance_frac  = pwdata[15:0];
                        REG_PERSIST: limits.persist_ms           = pwdata;
                        default: ;
                    endcase
                end else if (paddr[4:2] <= REG_PERSIST) begin
                    case (paddr[4:2])
                        REG_OV:      held = 32'(limits.cell_overvoltage_mv);
                        REG_UV:      held = 32'(limits.cell_undervoltage_mv);
                        REG_IMB:     held = 32'(limits.cell_imbalance_mv);
                        REG_TOL_MW:  held = 32'(limits.flow_tolerance_mw);
                        REG_TOL_FRC: held = 32'(limits.flow_tolerance_frac);
                        default:     held = limits.persist_ms;
                    endcase
                    if (prdata !== held) begin
                        log_mismatch($sformatf("register %0d read: exp %h got %h",
                                               paddr[4:2], held, prdata));
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (expected_grades.size() == 0) begin
                    log_mismatch($sformatf("result %h with no tick outstanding", m_payload));
                end else begin
                    want = expected_grades.pop_front();
                    graded++;
                    if (m_payload.fault_flags !== want.fault_flags
                        || m_payload.severity !== want.severity) begin
                        log_mismatch($sformatf(
                            "result %0d: flags exp %h got %h, severity exp %0d got %0d",
                            graded, want.fault_flags, m_payload.fault_flags,
                            want.severity, m_payload.severity));
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = grade_tick(s_payload);
                expected_grades.push_back(want);
                if (want.fault_flags[FF_FLOW]) begin
                    flow_alarms++;
                end
            end
        end
        pending = expected_grades.size();
    end

endmodule

// ===== test/battery_fault_aggregator_core_test.sv =====
// Testbench top for the battery fault aggregator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module battery_fault_aggregator_core_test;
    import bfa_pkg::*;

    localparam int unsigned CELL_COUNT = 4;
    localparam int          SLOTS      = 4;
    localparam int          LIMIT      = 400000;
    localparam cfg_t RESET_LIMITS = {RST_OV, RST_UV, RST_IMB, RST_TOL_MW, RST_TOL_FRC,
                                     RST_PERSIST};
    localparam logic [1:0] CELL_BAD   = 2'd2;
    localparam logic [1:0] CELL_ODD   = 2'd3;
    localparam logic [2:0] REG_SPARE_A = REG_PERSIST + 3'd1;
    localparam logic [2:0] REG_SPARE_B = REG_PERSIST + 3'd2;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_payload;
    logic        m_valid;
    logic        m_ready;
    out_t        m_payload;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int graded;
    int flow_alarms;

    cfg_t        cur;
    logic [31:0] clock_ms;
    int          burst_left;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          rx_hold_req;
    int          settings_count;
    int          ticks_sent;

    battery_fault_aggregator_core #(
        .CELL_COUNT(CELL_COUNT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    fault_flag_checker #(
        .CELL_COUNT(CELL_COUNT)
    ) flag_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .mismatches(mismatches),
        .pending(pending),
        .graded(graded),
        .flow_alarms(flow_alarms)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles, %0d results still outstanding", LIMIT, pending);
        $display("Verification failed");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                hold_left   = 200;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic read_back();
        int r;
        for (r = REG_OV; r <= REG_PERSIST; r++) begin
            apb_access(1'b0, 3'(r), '0);
        end
    endtask

    task automatic load_limits(input cfg_t c);
        apb_access(1'b1, REG_OV,      32'(c.cell_overvoltage_mv));
        apb_access(1'b1, REG_UV,      32'(c.cell_undervoltage_mv));
        apb_access(1'b1, REG_IMB,     32'(c.cell_imbalance_mv));
        apb_access(1'b1, REG_TOL_MW,  32'(c.flow_tolerance_mw));
        apb_access(1'b1, REG_TOL_FRC, 32'(c.flow_tolerance_frac));
        apb_access(1'b1, REG_PERSIST, c.persist_ms);
        read_back();
        cur = c;
        settings_count++;
    endtask

    task automatic offer(input in_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    function automatic in_t nominal();
        in_t t;
        t.validity_bits        = '1;
        t.device_present       = '1;
        t.cell_states          = {CELL_OK, CELL_OK, CELL_OK, CELL_OK};
        t.cell_voltages_mv     = {4{16'd3300}};
        t.cell_spread_mv       = 16'd20;
        t.flow_error_mw        = '0;
        t.inverter_power_mw    = '0;
        t.now_ms               = 32'd1;
        t.resistance_alarms    = '0;
        t.pack_resistance_uohm = '0;
        return t;
    endfunction

    function automatic cfg_t random_limits();
        cfg_t c;
        c.cell_overvoltage_mv  = 16'($urandom_range(4200, 3300));
        c.cell_undervoltage_mv = 16'($urandom_range(3200, 2500));
        c.cell_imbalance_mv    = 16'($urandom_range(300));
        c.flow_tolerance_mw    = ($urandom_range(1) == 0) ? 23'($urandom_range(20000))
                                                          : 23'($urandom);
        c.flow_tolerance_frac  = 16'($urandom);
        c.persist_ms           = ($urandom_range(1) == 0) ? $urandom_range(50)
                                                          : $urandom_range(20000, 100);
        return c;
    endfunction

    // mostly mismatch episodes on a running clock, mixed with noise and broken episodes
    function automatic in_t random_tick();
        in_t         t;
        logic [23:0] p, pmag, tol, mag;
        logic [39:0] prod;
        int          c;
        int unsigned pick;
        t.validity_bits  = ($urandom_range(3) == 0) ? 5'($urandom) : 5'b11111;
        t.device_present = ($urandom_range(3) == 0) ? 5'($urandom) : 5'b11111;
        for (c = 0; c < SLOTS; c++) begin
            pick = $urandom_range(9);
            t.cell_states[2*c +: 2] = (pick < 6) ? CELL_OK : (pick == 6) ? CELL_TAP
                                                           : 2'($urandom);
            case ($urandom_range(5))
                0: t.cell_voltages_mv[16*c +: 16] = cur.cell_overvoltage_mv
                                                    + 16'($urandom_range(2)) - 16'd1;
                1: t.cell_voltages_mv[16*c +: 16] = cur.cell_undervoltage_mv
                                                    + 16'($urandom_range(2)) - 16'd1;
                2: t.cell_voltages_mv[16*c +: 16] = 16'($urandom);
                3: t.cell_voltages_mv[16*c +: 16] = ($urandom_range(1) == 0) ? '0 : '1;
                default: t.cell_voltages_mv[16*c +: 16] =
                    16'($urandom_range(cur.cell_overvoltage_mv, cur.cell_undervoltage_mv));
            endcase
        end
        t.cell_spread_mv = ($urandom_range(1) == 0)
            ? cur.cell_imbalance_mv + 16'($urandom_range(2)) - 16'd1 : 16'($urandom);

        pick = $urandom_range(49);
        if (pick == 0) begin
            clock_ms = '0;
        end else if (pick == 1) begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(16);
        end else if (pick == 2) begin
            clock_ms = $urandom;
        end else if (pick > 5) begin
            clock_ms = clock_ms + $urandom_range((cur.persist_ms >> 2) + 1, 1);
        end
        t.now_ms = clock_ms;

        p = 24'($urandom) >> $urandom_range(20);
        if ($urandom_range(1) == 1) begin
            p = -p;
        end
        t.inverter_power_mw = p;
        pmag = p[23] ? -p : p;
        prod = pmag * cur.flow_tolerance_frac;
        tol  = (prod[39:16] > cur.flow_tolerance_mw) ? prod[39:16]
                                                     : 24'(cur.flow_tolerance_mw);
        if (burst_left == 0 && $urandom_range(9) < 3) begin
            burst_left = $urandom_range(25, 3);
        end
        if (burst_left > 0) begin
            burst_left--;
            t.validity_bits[VB_FLOW] = ($urandom_range(29) != 0);
            mag = 24'($urandom_range(32'h80_0000, 32'(tol) + 1));
            if ($urandom_range(19) == 0) begin
                mag = '0;
            end
        end else begin
            case ($urandom_range(3))
                0: mag = tol;
                1: mag = tol + 24'd1;
                2: mag = 24'($urandom);
                default: mag = '0;
            endcase
        end
        t.flow_error_mw = (mag[23] || $urandom_range(1) == 1) ? -mag : mag;

        t.resistance_alarms    = 2'($urandom);
        t.pack_resistance_uohm = ($urandom_range(3) == 0) ? '0 : 24'($urandom);
        return t;
    endfunction

    initial begin : stimulus
        in_t t;
        int  seg;
        int  n;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_payload      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 13;
        recv_idle_pct  = 58;
        rx_hold_req    = 1'b0;
        burst_left     = 0;
        clock_ms       = 32'd100;
        cur            = RESET_LIMITS;
        settings_count = 1;
        ticks_sent     = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        read_back();

        // directed ticks under reset limits
        t = nominal();
        offer(t);
        t.validity_bits  = '0;
        t.device_present = '0;
        offer(t);
        t = nominal();
        t.validity_bits[VB_METRICS] = 1'b0;
        t.cell_spread_mv = '1;
        offer(t);
        t = nominal();
        t.cell_spread_mv = RST_IMB + 16'd1;
        offer(t);
        t = nominal();
        t.device_present[DP_ADC_A] = 1'b0;
        t.device_present[DP_ADC_B] = 1'b0;
        offer(t);
        t = nominal();
        t.device_present[DP_CLIMATE] = 1'b0;
        offer(t);
        t = nominal();
        t.device_present[DP_BMON] = 1'b0;
        offer(t);
        t.device_present[DP_IMON] = 1'b0;
        offer(t);
        t = nominal();
        t.cell_states[7:6] = CELL_TAP;
        offer(t);
        t = nominal();
        t.cell_voltages_mv[15:0]  = RST_OV + 16'd1;
        t.cell_voltages_mv[31:16] = RST_OV;
        t.cell_voltages_mv[47:32] = RST_UV;
        offer(t);
        t = nominal();
        t.cell_voltages_mv[63:48] = RST_UV - 16'd1;
        offer(t);
        t = nominal();
        t.cell_states[1:0] = CELL_BAD;
        t.cell_states[3:2] = CELL_ODD;
        t.cell_voltages_mv[31:0] = 32'hFFFF_0000;
        offer(t);
        t = nominal();
        t.resistance_alarms = 2'b01;
        offer(t);
        t.resistance_alarms    = 2'b11;
        t.pack_resistance_uohm = '1;
        offer(t);
        // mismatch starting at the zero timestamp, then crossing the persistence time
        t = nominal();
        t.flow_error_mw     = 24'h80_0000;
        t.inverter_power_mw = 24'h80_0000;
        t.now_ms            = '0;
        offer(t);
        t.inverter_power_mw = '0;
        t.now_ms = 32'd5;
        offer(t);
        t.now_ms = 32'd10005;
        offer(t);
        t.now_ms = 32'd10006;
        offer(t);
        t.validity_bits[VB_FLOW] = 1'b0;
        t.now_ms = 32'd10007;
        offer(t);
        // elapsed time across the timestamp wrap, and tolerance edges
        t = nominal();
        t.flow_error_mw = 24'sd5001;
        t.now_ms = 32'hFFFF_FF00;
        offer(t);
        t.now_ms = 32'h0000_2800;
        offer(t);
        t.flow_error_mw = 24'sd5000;
        t.now_ms = 32'h0000_2801;
        offer(t);
        t.flow_error_mw     = 24'h7F_FFFF;
        t.inverter_power_mw = 24'h7F_FFFF;
        t.now_ms = '1;
        offer(t);
        t.now_ms = 32'd10000;
        offer(t);
        t.flow_error_mw = -24'sd838911;
        t.now_ms = 32'd10001;
        offer(t);
        settle();

        for (seg = 0; seg < 6; seg++) begin
            send_idle_pct = (seg < 2) ? 13 : (seg < 4) ? 58 : 0;
            recv_idle_pct = (seg < 2) ? 58 : (seg < 4) ? 13 : 0;
            case (seg)
                1: load_limits('0);
                3: load_limits('1);
                5: load_limits(RESET_LIMITS);
                default: load_limits(random_limits());
            endcase
            if (seg == 2) begin
                apb_access(1'b1, REG_SPARE_A, '1);
                apb_access(1'b1, REG_SPARE_B, '1);
                read_back();
            end
            for (n = 0; n < 250; n++) begin
                if ((seg == 1 || seg == 4) && n == 60) begin
                    rx_hold_req = 1'b1;
                end
                offer(random_tick());
            end
            settle();
        end

        repeat (8) @(posedge aclk);
        $display("Ran %0d ticks over %0d limit settings, %0d results graded",
                 ticks_sent, settings_count, graded);
        $display("Flow alarm expected on %0d results; stalls, hold-off and drains included",
                 flow_alarms);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
